>>> rtl/core/segment_to_quad_expander_defines.svh
// Shared assertion macros; the enclosing module provides clk and arst_n.
`ifndef SEGMENT_TO_QUAD_EXPANDER_DEFINES_SVH
`define SEGMENT_TO_QUAD_EXPANDER_DEFINES_SVH

// Same-cycle implication.
`define STQE_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define STQE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/stqe_pkg.sv
`default_nettype none

package stqe_pkg;

	localparam int COORD_WIDTH     = 32;
	localparam int INDEX_WIDTH     = 32;
	localparam int HALF_WIDTH_W    = 16;
	localparam int COLOR_W         = 8;
	localparam int CFG_DATA_W      = HALF_WIDTH_W;

	localparam int DIFF_W          = COORD_WIDTH + 1;
	localparam int MAG_W           = 15;
	localparam int NORM_LO         = 1 << (MAG_W - 1);
	localparam int NORM_HI         = 1 << MAG_W;
	localparam int L_W             = 2 * MAG_W + 1;
	localparam int Y_W             = 33;
	localparam int P_W             = 34;
	localparam int T_W             = 32;
	localparam int MUL_W           = 33;
	localparam int PROD_W          = 2 * MUL_W;
	localparam int OFS_W           = MAG_W + HALF_WIDTH_W - 7;
	localparam int OFS_SW          = OFS_W + 1;
	localparam int SUM_W           = ((COORD_WIDTH > OFS_SW) ? COORD_WIDTH : OFS_SW) + 1;

	localparam logic [Y_W-1:0] SEED_HI  = Y_W'(902905634);
	localparam logic [Y_W-1:0] SEED_MID = Y_W'(1276901417);
	localparam logic [Y_W-1:0] SEED_LO  = Y_W'(1805811268);
	localparam logic [P_W-1:0] THREE_Q30 = P_W'(64'd3 << 30);

	localparam int ITER_W          = 2;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(3);

	localparam int VERTS_PER_SEG   = 4;
	localparam int TRI_LAST        = 3;
	localparam int RESULTS_PER_SEG = 10;
	localparam int CNT_W           = $clog2(RESULTS_PER_SEG);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESULTS_PER_SEG - 1);

	typedef enum logic [1:0] {
		REG_HALF_WIDTH,
		REG_COLOR_RED,
		REG_COLOR_GREEN,
		REG_COLOR_BLUE
	} reg_index_t;

	typedef enum logic {
		KIND_VERTEX,
		KIND_INDEX
	} kind_t;

	typedef struct packed {
		logic [HALF_WIDTH_W-1:0] half_width;
		logic [COLOR_W-1:0]      color_red;
		logic [COLOR_W-1:0]      color_green;
		logic [COLOR_W-1:0]      color_blue;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic                          first_of_batch;
	} in_word_t;

	typedef struct packed {
		kind_t                         item_kind;
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic [COLOR_W-1:0]            out_red;
		logic [COLOR_W-1:0]            out_green;
		logic [COLOR_W-1:0]            out_blue;
		logic [INDEX_WIDTH-1:0]        index_value;
		logic                          last_of_segment;
		logic                          degenerate;
	} out_word_t;

	function automatic logic [1:0] tri_offset(input logic [2:0] k);
		logic [1:0] r;
		unique case (k)
			3'd0: r = 2'd0;
			3'd1: r = 2'd1;
			3'd2: r = 2'd2;
			3'd3: r = 2'd2;
			3'd4: r = 2'd1;
			3'd5: r = 2'(TRI_LAST);
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
		input logic signed [SUM_W-1:0] v
	);
		logic [SUM_W-COORD_WIDTH:0] top;
		logic signed [COORD_WIDTH-1:0] r;
		top = v[SUM_W-1:COORD_WIDTH-1];
		if (top == '0 || top == '1) begin
			r = v[COORD_WIDTH-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/segment_to_quad_expander.sv
// Channel   Direction  Handshake                      Word
// segment   in         segment_valid / segment_stall  stqe_pkg::in_word_t
// result    out        result_valid / result_stall    stqe_pkg::out_word_t
// config    in         wr_en, wr_index, wr_data       no handshake
//
// An accepted segment runs through the sequencer states in order, up to the last
// result word; a zero-length segment skips from the absolute values to the unit
// vector products. The shared 33x33 multiplier computes squares, four refinement
// steps of three products each, then the unit vector and offset products, one
// product per state. The normalize step shifts by four bits or one bit per step.
// Reset clears the sequencer, the vertex base and the output valid; config
// registers return to half width 256 and white. A stalled result holds the
// sequencer in its emit state; segment_stall is high whenever a segment is in work.
`default_nettype none

module segment_to_quad_expander (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            segment_valid,
	output logic                                 segment_stall,
	input  wire stqe_pkg::in_word_t              segment,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output stqe_pkg::out_word_t                  result,
	input  wire logic                            wr_en,
	input  wire stqe_pkg::reg_index_t            wr_index,
	input  wire logic [stqe_pkg::CFG_DATA_W-1:0] wr_data
);
	import stqe_pkg::*;

	cfg_t      cfg_q;
	out_word_t res;
	logic      res_valid;
	logic      res_ready;
	logic      result_valid_q;
	out_word_t result_q;

	stqe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (segment),
		.seg_valid (segment_valid),
		.seg_stall (segment_stall),
		.cfg       (cfg_q),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width  <= HALF_WIDTH_W'(256);
			cfg_q.color_red   <= '1;
			cfg_q.color_green <= '1;
			cfg_q.color_blue  <= '1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HALF_WIDTH:  cfg_q.half_width  <= wr_data;
				REG_COLOR_RED:   cfg_q.color_red   <= wr_data[COLOR_W-1:0];
				REG_COLOR_GREEN: cfg_q.color_green <= wr_data[COLOR_W-1:0];
				REG_COLOR_BLUE:  cfg_q.color_blue  <= wr_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// advance the output register when it is empty or being taken
	assign res_ready = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ready) begin
			result_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

>>> rtl/core/stqe_mul.sv
`default_nettype none

module stqe_mul (
	input  wire logic                       clk,
	input  wire logic [stqe_pkg::MUL_W-1:0] a,
	input  wire logic [stqe_pkg::MUL_W-1:0] b,
	output logic [stqe_pkg::PROD_W-1:0]     prod
);
	import stqe_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

>>> rtl/core/stqe_core.sv
`default_nettype none
`include "segment_to_quad_expander_defines.svh"

module stqe_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire stqe_pkg::in_word_t  seg,
	input  wire logic                seg_valid,
	output logic                     seg_stall,
	input  wire stqe_pkg::cfg_t      cfg,
	output stqe_pkg::out_word_t      res,
	output logic                     res_valid,
	input  wire logic                res_ready
);
	import stqe_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_ABS, S_NORM, S_SQA, S_SQB, S_LSUM,
		S_YY, S_LY, S_YT, S_YUP, S_UA, S_UB, S_OX, S_OY, S_OFS, S_EMIT
	} state_t;

	state_t                   state_q;
	logic [INDEX_WIDTH-1:0]   vertex_base_q;
	logic [INDEX_WIDTH-1:0]   base_q;
	logic signed [COORD_WIDTH-1:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [DIFF_W-1:0]        a_q, b_q;
	logic                     neg_x_q, neg_y_q, deg_q;
	logic [2*MAG_W-1:0]       aa_q;
	logic [L_W-1:0]           l_q;
	logic [Y_W-1:0]           y_q;
	logic [ITER_W-1:0]        iter_q;
	logic [MAG_W-1:0]         ux_q;
	logic signed [OFS_SW-1:0] ox_q, oy_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [MUL_W-1:0]         mul_a, mul_b;
	logic [PROD_W-1:0]        prod;
	logic [DIFF_W-1:0]        span;
	logic [L_W-1:0]           l_sum;
	logic [P_W-1:0]           p_val;
	logic [T_W-1:0]           t_val;
	logic [MAG_W-1:0]         u_clamp;
	logic [OFS_W-1:0]         ofs_mag;
	logic signed [OFS_SW-1:0] ofs_pos;
	logic signed [COORD_WIDTH-1:0] px, py;
	logic signed [SUM_W-1:0]  sx, sy;
	logic [CNT_W-1:0]         kk;
	logic                     is_vertex;

	stqe_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign span    = a_q | b_q;
	assign l_sum   = L_W'(aa_q) + L_W'(prod[2*MAG_W-1:0]);
	assign p_val   = prod[30 +: P_W];
	assign t_val   = (p_val < THREE_Q30) ? T_W'(THREE_Q30 - p_val) : '0;
	assign u_clamp = (|prod[PROD_W-1:30+MAG_W]) ? '1 : prod[30 +: MAG_W];
	assign ofs_mag = prod[7 +: OFS_W];
	assign ofs_pos = $signed({1'b0, ofs_mag});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQA: begin
				mul_a = MUL_W'(a_q[MAG_W-1:0]);
				mul_b = MUL_W'(a_q[MAG_W-1:0]);
			end
			S_SQB: begin
				mul_a = MUL_W'(b_q[MAG_W-1:0]);
				mul_b = MUL_W'(b_q[MAG_W-1:0]);
			end
			S_YY: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(y_q);
			end
			S_LY: begin
				mul_a = MUL_W'(l_q);
				mul_b = MUL_W'(prod[30 +: Y_W]);
			end
			S_YT: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(t_val);
			end
			S_UA: begin
				mul_a = MUL_W'(a_q[MAG_W-1:0]);
				mul_b = MUL_W'(y_q);
			end
			S_UB: begin
				mul_a = MUL_W'(b_q[MAG_W-1:0]);
				mul_b = MUL_W'(y_q);
			end
			S_OX: begin
				mul_a = MUL_W'(u_clamp);
				mul_b = MUL_W'(cfg.half_width);
			end
			S_OY: begin
				mul_a = MUL_W'(ux_q);
				mul_b = MUL_W'(cfg.half_width);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign px        = cnt_q[1] ? x1_q : x0_q;
	assign py        = cnt_q[1] ? y1_q : y0_q;
	assign sx        = cnt_q[0] ? SUM_W'(px) - SUM_W'(ox_q) : SUM_W'(px) + SUM_W'(ox_q);
	assign sy        = cnt_q[0] ? SUM_W'(py) - SUM_W'(oy_q) : SUM_W'(py) + SUM_W'(oy_q);
	assign kk        = cnt_q - CNT_W'(VERTS_PER_SEG);
	assign is_vertex = cnt_q < CNT_W'(VERTS_PER_SEG);

	always_comb begin
		res.degenerate      = deg_q;
		res.last_of_segment = (cnt_q == CNT_LAST);
		if (is_vertex) begin
			res.item_kind   = KIND_VERTEX;
			res.pos_x       = sat_coord(sx);
			res.pos_y       = sat_coord(sy);
			res.out_red     = cfg.color_red;
			res.out_green   = cfg.color_green;
			res.out_blue    = cfg.color_blue;
			res.index_value = '0;
		end else begin
			res.item_kind   = KIND_INDEX;
			res.pos_x       = '0;
			res.pos_y       = '0;
			res.out_red     = '0;
			res.out_green   = '0;
			res.out_blue    = '0;
			res.index_value = base_q + INDEX_WIDTH'(tri_offset(kk[2:0]));
		end
	end

	assign res_valid = (state_q == S_EMIT);
	assign seg_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vertex_base_q <= '0;
			base_q        <= '0;
			x0_q          <= '0;
			y0_q          <= '0;
			x1_q          <= '0;
			y1_q          <= '0;
			dx_q          <= '0;
			dy_q          <= '0;
			a_q           <= '0;
			b_q           <= '0;
			neg_x_q       <= 1'b0;
			neg_y_q       <= 1'b0;
			deg_q         <= 1'b0;
			aa_q          <= '0;
			l_q           <= '0;
			y_q           <= '0;
			iter_q        <= '0;
			ux_q          <= '0;
			ox_q          <= '0;
			oy_q          <= '0;
			cnt_q         <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (seg_valid) begin
						x0_q   <= seg.start_x;
						y0_q   <= seg.start_y;
						x1_q   <= seg.end_x;
						y1_q   <= seg.end_y;
						base_q <= seg.first_of_batch ? '0 : vertex_base_q;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					dx_q    <= DIFF_W'(x1_q) - DIFF_W'(x0_q);
					dy_q    <= DIFF_W'(y1_q) - DIFF_W'(y0_q);
					state_q <= S_ABS;
				end
				S_ABS: begin
					a_q     <= dx_q[DIFF_W-1] ? $unsigned(-dx_q) : $unsigned(dx_q);
					b_q     <= dy_q[DIFF_W-1] ? $unsigned(-dy_q) : $unsigned(dy_q);
					neg_x_q <= dx_q[DIFF_W-1];
					neg_y_q <= dy_q[DIFF_W-1];
					deg_q   <= (dx_q == '0) && (dy_q == '0);
					y_q     <= '0;
					state_q <= ((dx_q == '0) && (dy_q == '0)) ? S_UA : S_NORM;
				end
				S_NORM: begin
					priority if (|span[DIFF_W-1:MAG_W+4]) begin
						a_q <= a_q >> 4;
						b_q <= b_q >> 4;
					end else if (|span[DIFF_W-1:MAG_W]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
					end else if (span[MAG_W-1:MAG_W-5] == '0) begin
						a_q <= a_q << 4;
						b_q <= b_q << 4;
					end else if (!span[MAG_W-1]) begin
						a_q <= a_q << 1;
						b_q <= b_q << 1;
					end else begin
						state_q <= S_SQA;
					end
				end
				S_SQA: begin
					state_q <= S_SQB;
				end
				S_SQB: begin
					aa_q    <= prod[2*MAG_W-1:0];
					state_q <= S_LSUM;
				end
				S_LSUM: begin
					l_q     <= l_sum;
					iter_q  <= '0;
					priority if (l_sum[L_W-1]) begin
						y_q <= SEED_HI;
					end else if (l_sum[L_W-2]) begin
						y_q <= SEED_MID;
					end else begin
						y_q <= SEED_LO;
					end
					state_q <= S_YY;
				end
				S_YY: begin
					state_q <= S_LY;
				end
				S_LY: begin
					state_q <= S_YT;
				end
				S_YT: begin
					state_q <= S_YUP;
				end
				S_YUP: begin
					y_q     <= prod[31 +: Y_W];
					iter_q  <= iter_q + ITER_W'(1);
					state_q <= (iter_q == ITER_LAST) ? S_UA : S_YY;
				end
				S_UA: begin
					state_q <= S_UB;
				end
				S_UB: begin
					ux_q    <= u_clamp;
					state_q <= S_OX;
				end
				S_OX: begin
					state_q <= S_OY;
				end
				S_OY: begin
					ox_q    <= neg_y_q ? ofs_pos : -ofs_pos;
					state_q <= S_OFS;
				end
				S_OFS: begin
					oy_q    <= neg_x_q ? -ofs_pos : ofs_pos;
					cnt_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_LAST) begin
							vertex_base_q <= base_q + INDEX_WIDTH'(VERTS_PER_SEG);
							state_q       <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`STQE_ASSERT_NOW(a_norm_range, state_q == S_SQA, (span >= DIFF_W'(NORM_LO)) && (span < DIFF_W'(NORM_HI)), "normalized span out of range")
	`STQE_ASSERT_NOW(a_deg_zero, (state_q == S_UA) && deg_q, (a_q == '0) && (b_q == '0), "zero-length segment with nonzero magnitude")
	`STQE_ASSERT_NEXT(a_last_idle, res_valid && res_ready && res.last_of_segment, state_q == S_IDLE, "sequencer did not return to idle after last word")
	`STQE_ASSERT_NEXT(a_iter_exit, (state_q == S_YUP) && (iter_q == ITER_LAST), state_q == S_UA, "refinement loop overran")

endmodule

`default_nettype wire

>>> tb/segment_to_quad_expander_tb.sv
module segment_to_quad_expander_tb;
	import stqe_pkg::*;

	localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam longint UNIT_MAX = NORM_HI - 1;
	localparam int INDEX_WORDS = RESULTS_PER_SEG - VERTS_PER_SEG;
	localparam logic [31:0] ONE = 32'h0001_0000;

	typedef struct packed {
		in_word_t word;
		logic     wait_drain;
	} queued_segment_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  segment_valid = 1'b0;
	logic                  segment_stall;
	in_word_t              segment = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	out_word_t             result;
	logic                  wr_en = 1'b0;
	reg_index_t            wr_index = REG_HALF_WIDTH;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	queued_segment_t        segments_to_send[$];
	out_word_t              quad_words_due[$];
	cfg_t                   cfg_model;
	logic [INDEX_WIDTH-1:0] vertex_base_model;
	int                     send_idle_pct = 0;
	int                     stall_pct = 0;
	int                     mismatch_count = 0;
	int                     words_checked = 0;

	segment_to_quad_expander dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.segment_valid (segment_valid),
		.segment_stall (segment_stall),
		.segment       (segment),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always #4 clk = ~clk;

	function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
		longint r;
		r = v;
		if (v > COORD_MAX)
			r = COORD_MAX;
		else if (v < COORD_MIN)
			r = COORD_MIN;
		return r[COORD_WIDTH-1:0];
	endfunction

	function automatic longint scaled_offset(longint p);
		longint unsigned pm;
		longint unsigned mg;
		pm = (p < 0) ? -p : p;
		mg = (pm * cfg_model.half_width) >> 7;
		return (p < 0) ? -longint'(mg) : longint'(mg);
	endfunction

	function automatic void expand_segment(in_word_t s);
		longint x0, y0, x1, y1, dx, dy, ux, uy, ox, oy, px, py;
		longint unsigned a, b, m, len2, y, y2, prod, t;
		logic deg;
		logic [INDEX_WIDTH-1:0] base;
		out_word_t w;
		x0 = $signed(s.start_x);
		y0 = $signed(s.start_y);
		x1 = $signed(s.end_x);
		y1 = $signed(s.end_y);
		dx = x1 - x0;
		dy = y1 - y0;
		a = (dx < 0) ? -dx : dx;
		b = (dy < 0) ? -dy : dy;
		ux = 0;
		uy = 0;
		deg = 1'b0;
		if (a == 0 && b == 0) begin
			deg = 1'b1;
		end else begin
			m = (a > b) ? a : b;
			while (m >= NORM_HI) begin
				a >>= 1;
				b >>= 1;
				m >>= 1;
			end
			while (m < NORM_LO) begin
				a <<= 1;
				b <<= 1;
				m <<= 1;
			end
			len2 = a * a + b * b;
			if (len2 >= (64'd1 << 30))
				y = SEED_HI;
			else if (len2 >= (64'd1 << 29))
				y = SEED_MID;
			else
				y = SEED_LO;
			repeat (4) begin
				y2 = (y * y) >> 30;
				prod = (len2 * y2) >> 30;
				t = (prod < THREE_Q30) ? THREE_Q30 - prod : 0;
				y = (y * t) >> 31;
			end
			ux = (a * y) >> 30;
			uy = (b * y) >> 30;
			if (ux > UNIT_MAX)
				ux = UNIT_MAX;
			if (uy > UNIT_MAX)
				uy = UNIT_MAX;
			if (dx < 0)
				ux = -ux;
			if (dy < 0)
				uy = -uy;
		end
		ox = scaled_offset(-uy);
		oy = scaled_offset(ux);
		for (int c = 0; c < VERTS_PER_SEG; c++) begin
			px = (c < 2) ? x0 : x1;
			py = (c < 2) ? y0 : y1;
			w = '0;
			w.item_kind = KIND_VERTEX;
			w.pos_x = clamp_coord((c % 2) ? px - ox : px + ox);
			w.pos_y = clamp_coord((c % 2) ? py - oy : py + oy);
			w.out_red = cfg_model.color_red;
			w.out_green = cfg_model.color_green;
			w.out_blue = cfg_model.color_blue;
			w.degenerate = deg;
			quad_words_due.insert(quad_words_due.size(), w);
		end
		base = s.first_of_batch ? '0 : vertex_base_model;
		for (int k = 0; k < INDEX_WORDS; k++) begin
			w = '0;
			w.item_kind = KIND_INDEX;
			w.index_value = base + ((k == INDEX_WORDS - 1) ? TRI_LAST : ((k < 3) ? k : 5 - k));
			w.last_of_segment = (k == INDEX_WORDS - 1);
			w.degenerate = deg;
			quad_words_due.insert(quad_words_due.size(), w);
		end
		vertex_base_model = base + VERTS_PER_SEG;
	endfunction

	function automatic in_word_t make_segment(logic [31:0] x0, logic [31:0] y0,
			logic [31:0] x1, logic [31:0] y1, logic first);
		in_word_t s;
		s.start_x = x0;
		s.start_y = y0;
		s.end_x = x1;
		s.end_y = y1;
		s.first_of_batch = first;
		return s;
	endfunction

	function automatic in_word_t random_segment();
		in_word_t s;
		logic [31:0] delta_x, delta_y;
		int pick;
		pick = $urandom_range(99);
		s.start_x = $urandom;
		s.start_y = $urandom;
		delta_x = $urandom >> $urandom_range(31);
		delta_y = $urandom >> $urandom_range(31);
		if ($urandom_range(1))
			delta_x = -delta_x;
		if ($urandom_range(1))
			delta_y = -delta_y;
		if (pick < 10) begin
			delta_x = '0;
			delta_y = '0;
		end else if (pick < 20) begin
			if ($urandom_range(1))
				delta_x = '0;
			else
				delta_y = '0;
		end else if (pick < 35) begin
			delta_x = $urandom;
			delta_y = $urandom;
		end else if (pick < 50) begin
			s.start_x = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(32'hF_FFFF)
				: 32'h8000_0000 + $urandom_range(32'hF_FFFF);
			s.start_y = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(32'hF_FFFF)
				: 32'h8000_0000 + $urandom_range(32'hF_FFFF);
			delta_x = $urandom >> $urandom_range(31, 10);
			delta_y = $urandom >> $urandom_range(31, 10);
			if ($urandom_range(1))
				delta_x = -delta_x;
			if ($urandom_range(1))
				delta_y = -delta_y;
		end
		s.end_x = s.start_x + delta_x;
		s.end_y = s.start_y + delta_y;
		s.first_of_batch = ($urandom_range(9) == 0);
		return s;
	endfunction

	task automatic queue_segment(in_word_t w, logic drain);
		queued_segment_t q;
		q.word = w;
		q.wait_drain = drain;
		segments_to_send.insert(segments_to_send.size(), q);
	endtask

	task automatic note_mismatch(string msg);
		mismatch_count++;
		$display("word %0d: %s", words_checked, msg);
	endtask

	task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			REG_HALF_WIDTH: cfg_model.half_width = value;
			REG_COLOR_RED: cfg_model.color_red = value[COLOR_W-1:0];
			REG_COLOR_GREEN: cfg_model.color_green = value[COLOR_W-1:0];
			REG_COLOR_BLUE: cfg_model.color_blue = value[COLOR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic write_all(logic [CFG_DATA_W-1:0] hw, logic [CFG_DATA_W-1:0] r,
			logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] b);
		write_reg(REG_HALF_WIDTH, hw);
		write_reg(REG_COLOR_RED, r);
		write_reg(REG_COLOR_GREEN, g);
		write_reg(REG_COLOR_BLUE, b);
	endtask

	task automatic wait_drained(int settle);
		while (segments_to_send.size() > 0 || quad_words_due.size() > 0 || segment_valid)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic run_phase(int count, int drain_odds);
		repeat (count)
			queue_segment(random_segment(), $urandom_range(drain_odds - 1) == 0);
		wait_drained(4);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		queued_segment_t head;
		if (!arst_n) begin
			segment_valid <= 1'b0;
		end else begin
			if (segment_valid && !segment_stall)
				expand_segment(segment);
			if (!segment_valid || !segment_stall) begin
				if (segments_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct
						&& !(segments_to_send[0].wait_drain && quad_words_due.size() > 0)) begin
					head = segments_to_send.pop_front();
					segment <= head.word;
					segment_valid <= 1'b1;
				end else begin
					segment_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : observe
		out_word_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (quad_words_due.size() == 0) begin
					note_mismatch($sformatf("unexpected word %h", result));
				end else begin
					want = quad_words_due.pop_front();
					if (result.item_kind !== want.item_kind)
						note_mismatch($sformatf("item_kind got %0d want %0d",
							result.item_kind, want.item_kind));
					if (result.pos_x !== want.pos_x)
						note_mismatch($sformatf("pos_x got %h want %h", result.pos_x, want.pos_x));
					if (result.pos_y !== want.pos_y)
						note_mismatch($sformatf("pos_y got %h want %h", result.pos_y, want.pos_y));
					if (result.out_red !== want.out_red)
						note_mismatch($sformatf("out_red got %h want %h",
							result.out_red, want.out_red));
					if (result.out_green !== want.out_green)
						note_mismatch($sformatf("out_green got %h want %h",
							result.out_green, want.out_green));
					if (result.out_blue !== want.out_blue)
						note_mismatch($sformatf("out_blue got %h want %h",
							result.out_blue, want.out_blue));
					if (result.index_value !== want.index_value)
						note_mismatch($sformatf("index_value got %h want %h",
							result.index_value, want.index_value));
					if (result.last_of_segment !== want.last_of_segment)
						note_mismatch($sformatf("last_of_segment got %b want %b",
							result.last_of_segment, want.last_of_segment));
					if (result.degenerate !== want.degenerate)
						note_mismatch($sformatf("degenerate got %b want %b",
							result.degenerate, want.degenerate));
				end
				words_checked++;
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		cfg_model.half_width = 16'd256;
		cfg_model.color_red = 8'd255;
		cfg_model.color_green = 8'd255;
		cfg_model.color_blue = 8'd255;
		vertex_base_model = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queue_segment(make_segment(32'h0, 32'h0, 32'h0, 32'h0, 1'b1), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, ONE, 32'h0, 1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, 32'h0, -ONE, 1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, 5 * ONE, 5 * ONE, 1'b0), 1'b0);
		queue_segment(make_segment(32'd100, 32'd200, 32'd101, 32'd200, 1'b0), 1'b0);
		queue_segment(make_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			1'b0), 1'b0);
		queue_segment(make_segment(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, ONE, 1'b0), 1'b0);
		queue_segment(make_segment(32'h8000_0000, 32'h0, 32'h8000_0000, -ONE, 1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h7FFF_FFFF, ONE, 32'h7FFF_FFFF, 1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h8000_0000, -ONE, 32'h8000_0000, 1'b0), 1'b0);
		queue_segment(make_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, 32'd16384, 32'h0, 1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, 32'd16384, 32'd16384, 1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, 32'd32767, 32'd32767, 1'b0), 1'b1);
		queue_segment(make_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			1'b1), 1'b0);
		queue_segment(make_segment(-3 * ONE, 2 * ONE, 4 * ONE, -7 * ONE, 1'b0), 1'b0);
		queue_segment(make_segment(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF3,
			1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, 32'd3, -32'd4, 1'b0), 1'b0);
		queue_segment(make_segment(ONE, 32'h0, 32'h0, 32'h0, 1'b0), 1'b0);
		queue_segment(make_segment(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 1'b1), 1'b0);
		run_phase(30, 1000);

		send_idle_pct = 51;
		write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_phase(55, 1000);

		send_idle_pct = 0;
		stall_pct = 51;
		write_all(16'hFFFF, 16'h00FF, 16'hFF00, 16'hABAA);
		run_phase(55, 1000);

		send_idle_pct = 16;
		stall_pct = 16;
		write_all(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
			CFG_DATA_W'($urandom));
		run_phase(60, 1000);

		send_idle_pct = 0;
		stall_pct = 0;
		write_all(CFG_DATA_W'($urandom_range(16'h0400)), CFG_DATA_W'($urandom),
			CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
		run_phase(60, 20);

		wait_drained(50);
		if (mismatch_count == 0)
			$display("segment_to_quad_expander: match");
		else
			$display("segment_to_quad_expander: mismatch");
		$finish;
	end

	initial begin
		#4000000;
		$display("segment_to_quad_expander: mismatch");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/stqe_pkg.sv
rtl/core/stqe_mul.sv
rtl/core/stqe_core.sv
rtl/core/segment_to_quad_expander.sv
tb/segment_to_quad_expander_tb.sv
